### sv/pinhole_point_projection_macros.svh
// Assertion macros for the pinhole point projection block.
// Used by the top level only; no dependencies.
`ifndef PINHOLE_POINT_PROJECTION_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_MACROS_SVH

// Property checked outside reset.
`define PPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every edge, reset included.
`define PPP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/ppp_pkg.sv
// Shared constants and types for the pinhole point projection block.
// No dependencies.
package ppp_pkg;
   localparam int COORD_W  = 32;
   localparam int MTX_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int NUM_REGS = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PROD_W   = MTX_W + COORD_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int MAG_W    = SUM_W;
   localparam int NUM_W    = MAG_W + FRAC_W;
   localparam int QUO_W    = COORD_W + 1;
   localparam int DSH_W    = MAG_W + QUO_W - 1;
   localparam int NUM_CELLS = QUO_W;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             big;
      logic             num_neg;
      logic             num_zero;
   } ppp_lane_type;

   typedef struct packed {
      ppp_lane_type     u;
      ppp_lane_type     v;
      logic [DSH_W-1:0] dsh;
      logic             den_zero;
   } ppp_div_type;
endpackage

### sv/ppp_if.sv
// Channel interfaces: point requests, image responses, register writes.
// Depends on ppp_pkg.
interface ppp_req_if import ppp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] point_x;
   logic [COORD_W-1:0] point_y;
   logic [COORD_W-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_rsp_if import ppp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] image_u;
   logic [COORD_W-1:0] image_v;
   logic               invalid;
   modport source (output valid, image_u, image_v, invalid, input ready);
   modport sink (input valid, image_u, image_v, invalid, output ready);
endinterface

interface ppp_csr_if import ppp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/ppp_front.sv
// Front end: row dot products of the projection matrix with a point,
// then magnitudes, signs and the overflow pre-check. Depends on ppp_pkg.
module ppp_front import ppp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [COORD_W-1:0]        point_x,
   input  logic [COORD_W-1:0]        point_y,
   input  logic [COORD_W-1:0]        point_z,
   input  logic [CSR_DATA_W-1:0]     mtx [NUM_REGS],
   output logic                      out_valid,
   output ppp_div_type               out_data
);
   logic [2:0]              vld_ff, vld_in;
   logic signed [PROD_W-1:0] prod_ff [3][4];
   logic signed [PROD_W-1:0] prod_in [3][4];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   ppp_div_type             div_ff, div_in;
   logic signed [PROD_W-1:0] crd [3];
   logic [MAG_W-1:0]        mag [3];
   logic [NUM_W-1:0]        num_u, num_v;

   always_comb begin
      crd[0] = PROD_W'($signed(point_x));
      crd[1] = PROD_W'($signed(point_y));
      crd[2] = PROD_W'($signed(point_z));
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = PROD_W'($signed(mtx[r*2 + c/2][(c%2)*MTX_W +: MTX_W])) * crd[c];
         end
         // translation column times 1.0
         prod_in[r][3] = $signed({{(PROD_W-MTX_W-FRAC_W){mtx[r*2+1][2*MTX_W-1]}},
                                  mtx[r*2+1][MTX_W +: MTX_W], {FRAC_W{1'b0}}});
      end
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                   + SUM_W'(prod_ff[r][2]) + SUM_W'(prod_ff[r][3]);
      end
      for (int r = 0; r < 3; r++) begin
         mag[r] = sum_ff[r][SUM_W-1] ? MAG_W'(-sum_ff[r]) : MAG_W'(sum_ff[r]);
      end
      num_u = {mag[0], {FRAC_W{1'b0}}};
      num_v = {mag[1], {FRAC_W{1'b0}}};
      div_in.u.rem      = num_u;
      div_in.u.quo      = '0;
      div_in.u.neg      = sum_ff[0][SUM_W-1] ^ sum_ff[2][SUM_W-1];
      div_in.u.big      = MAG_W'(num_u >> QUO_W) >= mag[2];
      div_in.u.num_neg  = sum_ff[0][SUM_W-1];
      div_in.u.num_zero = (sum_ff[0] == '0);
      div_in.v.rem      = num_v;
      div_in.v.quo      = '0;
      div_in.v.neg      = sum_ff[1][SUM_W-1] ^ sum_ff[2][SUM_W-1];
      div_in.v.big      = MAG_W'(num_v >> QUO_W) >= mag[2];
      div_in.v.num_neg  = sum_ff[1][SUM_W-1];
      div_in.v.num_zero = (sum_ff[1] == '0);
      div_in.dsh        = {mag[2], {(QUO_W-1){1'b0}}};
      div_in.den_zero   = (sum_ff[2] == '0);
      vld_in = {vld_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         div_ff  <= div_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_data  = div_ff;
endmodule

### sv/ppp_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both lanes
// and hands the shifted divisor on. Depends on ppp_pkg.
module ppp_div_cell import ppp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  ppp_div_type in_data,
   output logic        out_valid,
   output ppp_div_type out_data
);
   logic        vld_ff;
   ppp_div_type dat_ff, dat_in;
   logic        ge_u, ge_v;

   always_comb begin
      ge_u = DSH_W'(in_data.u.rem) >= in_data.dsh;
      ge_v = DSH_W'(in_data.v.rem) >= in_data.dsh;
      dat_in       = in_data;
      dat_in.dsh   = in_data.dsh >> 1;
      dat_in.u.quo = {in_data.u.quo[QUO_W-2:0], ge_u};
      dat_in.v.quo = {in_data.v.quo[QUO_W-2:0], ge_v};
      if (ge_u) begin
         dat_in.u.rem = in_data.u.rem - in_data.dsh[NUM_W-1:0];
      end
      if (ge_v) begin
         dat_in.v.rem = in_data.v.rem - in_data.dsh[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff <= dat_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = dat_ff;
endmodule

### sv/pinhole_point_projection.sv
// Pinhole point projection top level: registers, front end, division chain,
// output saturation. Depends on ppp_pkg, ppp_if, ppp_front, ppp_div_cell.
//
// Usage: write the 3x4 projection matrix (Q16.16 words, two per register,
// even column in the low half) through csr_bus while no point is in flight;
// csr_bus is always ready and indexes above 5 are dropped. Send points
// (x, y, z in Q16.16) on req_bus; each gives one beat on rsp_bus with u, v
// and an invalid flag for zero depth or a saturated quotient.
// The path has 37 register stages, the first loaded at the edge that accepts
// a point: three front-end stages (products, row sums, magnitudes), 33
// division cells (one quotient bit each), one output register.
// Throughput: one point per cycle unless stalled; every stage advances together.
// Stall: while rsp_bus holds a beat that is not taken, the whole pipeline
// holds and req_bus.ready drops; it rises again the cycle the beat is taken.
// Reset clears all pipeline valid bits and the matrix registers to zero.
module pinhole_point_projection import ppp_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   ppp_req_if.sink   req_bus,
   ppp_rsp_if.source rsp_bus,
   ppp_csr_if.sink   csr_bus
);
`include "pinhole_point_projection_macros.svh"

   logic [CSR_DATA_W-1:0] mtx_ff [NUM_REGS];
   logic                  en;
   logic                  cell_vld [NUM_CELLS+1];
   ppp_div_type           cell_dat [NUM_CELLS+1];
   logic                  out_vld_ff;
   logic [COORD_W-1:0]    u_ff, v_ff, u_in, v_in;
   logic                  inv_ff, inv_in;

   function automatic logic [COORD_W:0] sat_lane(ppp_lane_type ln, logic den_zero);
      logic [QUO_W-1:0]   lim;
      logic [QUO_W-1:0]   mag;
      logic               ovf;
      logic [COORD_W-1:0] val;
      lim = ln.neg ? (QUO_W'(1) << (COORD_W-1)) : ((QUO_W'(1) << (COORD_W-1)) - 1'b1);
      ovf = ln.big || (ln.quo > lim);
      mag = ovf ? lim : ln.quo;
      val = ln.neg ? COORD_W'(-mag) : COORD_W'(mag);
      if (den_zero) begin
         ovf = 1'b1;
         if (ln.num_zero) begin
            val = '0;
         end else if (ln.num_neg) begin
            val = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            val = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
      return {ovf, val};
   endfunction

   assign en            = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = en;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            mtx_ff[i] <= '0;
         end
      end else if (csr_bus.valid && (csr_bus.index < CSR_IDX_W'(NUM_REGS))) begin
         mtx_ff[csr_bus.index] <= csr_bus.data;
      end
   end

   ppp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .point_x   (req_bus.point_x),
      .point_y   (req_bus.point_y),
      .point_z   (req_bus.point_z),
      .mtx       (mtx_ff),
      .out_valid (cell_vld[0]),
      .out_data  (cell_dat[0])
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      ppp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cell_vld[g]),
         .in_data   (cell_dat[g]),
         .out_valid (cell_vld[g+1]),
         .out_data  (cell_dat[g+1])
      );
   end

   always_comb begin
      logic [COORD_W:0] ru, rv;
      ru     = sat_lane(cell_dat[NUM_CELLS].u, cell_dat[NUM_CELLS].den_zero);
      rv     = sat_lane(cell_dat[NUM_CELLS].v, cell_dat[NUM_CELLS].den_zero);
      u_in   = ru[COORD_W-1:0];
      v_in   = rv[COORD_W-1:0];
      inv_in = ru[COORD_W] || rv[COORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= cell_vld[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         inv_ff <= inv_in;
      end
   end

   assign rsp_bus.valid   = out_vld_ff;
   assign rsp_bus.image_u = u_ff;
   assign rsp_bus.image_v = v_ff;
   assign rsp_bus.invalid = inv_ff;

   `PPP_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_bus.valid, "response valid after reset")
   `PPP_ASSERT(a_stall_hold, rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(u_ff), "stalled beat lost")
   `PPP_ASSERT(a_chain_hold, !en && cell_vld[0] |=> cell_vld[1] == $past(cell_vld[1]), "chain moved during stall")
endmodule
